/* hw/rtl/ilpm_pkg.sv */
// Package for the IPv4 longest prefix match block.
// Holds table sizes, field widths, the probe and write structs, the state type and the mask function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ilpm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PEER_COUNT    = 16;

    localparam int ADDR_W  = 32;
    localparam int ENTRY_W = 6;
    localparam int PFX_W   = 6;
    localparam int PEER_W  = 4;

    localparam logic [PFX_W-1:0]  MAX_PREFIX = PFX_W'(32);
    localparam logic [ADDR_W-1:0] ADDR_MASK  = 32'hffff_ffff;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic               found;
        logic [PFX_W-1:0]   pfx;
        logic [PEER_W-1:0]  peer;
        logic [ENTRY_W-1:0] slot;
    } t_probe;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] idx;
        logic               ok;
        logic [ADDR_W-1:0]  net;
        logic [PFX_W-1:0]   pfx;
        logic [PEER_W-1:0]  peer;
    } t_write;

    // prefix is at most 32 for any stored entry
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PFX_W-1:0] pfx);
        logic [ADDR_W-1:0] m;
        if (pfx >= MAX_PREFIX) begin
            m = ADDR_MASK;
        end else begin
            m = ~(ADDR_MASK >> pfx);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ilpm_cell.sv */
// One route slot of the match chain: holds the entry and updates the passing probe.
// Depends on ilpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilpm_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [ilpm_pkg::ENTRY_W-1:0] i_slot,
    input  wire ilpm_pkg::t_write       i_wr,
    input  wire logic                   i_vld,
    input  wire ilpm_pkg::t_probe       i_probe,
    output logic                        o_vld,
    output ilpm_pkg::t_probe            o_probe
);
    import ilpm_pkg::*;

    logic                r_valid;
    logic [ADDR_W-1:0]   r_net;
    logic [PFX_W-1:0]    r_pfx;
    logic [PEER_W-1:0]   r_peer;
    logic                r_vld;
    t_probe              r_probe;
    t_probe              n_probe;
    logic                w_sel;
    logic                w_match;

    assign w_sel = i_wr.en && (i_wr.idx == i_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= i_wr.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.ok) begin
            r_net  <= i_wr.net;
            r_pfx  <= i_wr.pfx;
            r_peer <= i_wr.peer;
        end
    end

    always_comb begin
        w_match = r_valid && (((i_probe.addr ^ r_net) & prefix_mask(r_pfx)) == '0)
                  && (!i_probe.found || (r_pfx > i_probe.pfx));
        n_probe = i_probe;
        if (w_match) begin
            n_probe.found = 1'b1;
            n_probe.pfx   = r_pfx;
            n_probe.peer  = r_peer;
            n_probe.slot  = i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
    end

    assign o_vld   = r_vld;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

/* hw/rtl/ipv4_longest_prefix_match_top.sv */
// Top level of the IPv4 longest prefix match block.
// Holds the control state machine and the chain of ilpm_cell slots; depends on ilpm_pkg.
//
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   mode selects a table write (entry_index, entry_enable, route_network,
//   route_prefix, route_peer) or a lookup (lookup_address).
//   Every transaction yields one result on the o_ ports, marked by o_done for
//   exactly one cycle; the receiver cannot stall, so results are never held.
//   A write updates its slot at the accepting edge; its all-zero result comes
//   in the next cycle and busy stays low, so writes may follow every cycle.
//   A lookup probe enters slot 0 and moves one slot per cycle through the
//   chain of TABLE_ENTRIES cells, each comparing its own entry. Its result
//   is taken from the output register of the last cell, and busy is high
//   from acceptance through the result cycle, so a new transaction is only
//   accepted once the previous lookup has returned its result.
//   Reset clears all slot valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_longest_prefix_match_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [ilpm_pkg::ENTRY_W-1:0]  i_entry_index,
    input  wire logic                          i_entry_enable,
    input  wire logic [ilpm_pkg::ADDR_W-1:0]   i_route_network,
    input  wire logic [ilpm_pkg::PFX_W-1:0]    i_route_prefix,
    input  wire logic [ilpm_pkg::PEER_W-1:0]   i_route_peer,
    input  wire logic [ilpm_pkg::ADDR_W-1:0]   i_lookup_address,
    output logic                               o_done,
    output logic                               o_hit,
    output logic [ilpm_pkg::PEER_W-1:0]        o_matched_peer,
    output logic [ilpm_pkg::PFX_W-1:0]         o_matched_prefix,
    output logic [ilpm_pkg::ENTRY_W-1:0]       o_matched_slot
);
    import ilpm_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_wr_done;
    logic    w_accept;
    logic    w_lookup;
    t_write  w_wr;
    logic    w_vld   [TABLE_ENTRIES+1];
    t_probe  w_probe [TABLE_ENTRIES+1];
    t_probe  w_last;

    assign w_accept = start && !busy;
    assign w_lookup = w_accept && (i_mode == MODE_LOOKUP);

    always_comb begin
        w_wr.en   = w_accept && (i_mode == MODE_WRITE)
                    && (32'(i_entry_index) < TABLE_ENTRIES);
        w_wr.idx  = i_entry_index;
        w_wr.ok   = i_entry_enable && (i_route_prefix <= MAX_PREFIX)
                    && (32'(i_route_peer) < PEER_COUNT);
        w_wr.net  = i_route_network;
        w_wr.pfx  = i_route_prefix;
        w_wr.peer = i_route_peer;
    end

    assign w_vld[0]   = w_lookup;
    assign w_probe[0] = {i_lookup_address, {($bits(t_probe) - ADDR_W){1'b0}}};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ilpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (ENTRY_W'(g)),
            .i_wr    (w_wr),
            .i_vld   (w_vld[g]),
            .i_probe (w_probe[g]),
            .o_vld   (w_vld[g+1]),
            .o_probe (w_probe[g+1])
        );
    end

    assign w_last = w_probe[TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr_done <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_done <= w_wr.en || (w_accept && (i_mode == MODE_WRITE));
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_lookup) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                busy = 1'b1;
                if (w_vld[TABLE_ENTRIES]) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done           = r_wr_done || w_vld[TABLE_ENTRIES];
        o_hit            = 1'b0;
        o_matched_peer   = '0;
        o_matched_prefix = '0;
        o_matched_slot   = '0;
        if (w_vld[TABLE_ENTRIES] && w_last.found) begin
            o_hit            = 1'b1;
            o_matched_peer   = w_last.peer;
            o_matched_prefix = w_last.pfx;
            o_matched_slot   = w_last.slot;
        end
    end

    a_busy_ends_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> $past(o_done))
        else $error("busy dropped without a lookup result");

    a_lookup_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_LOOKUP)) |=> busy)
        else $error("lookup accepted but block not busy");

    a_hit_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_done)
        else $error("hit without result strobe");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |->
        (o_matched_peer == '0 && o_matched_prefix == '0 && o_matched_slot == '0))
        else $error("miss or write result carries nonzero fields");

    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (o_matched_prefix <= MAX_PREFIX))
        else $error("matched prefix above 32");

    a_no_result_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_done && w_vld[TABLE_ENTRIES]))
        else $error("write and lookup results in the same cycle");

endmodule

`default_nettype wire

/* sim/ipv4_longest_prefix_match_top_tb.sv */
// Self-checking testbench for the IPv4 longest prefix match block (ipv4_longest_prefix_match_top).
// A scoreboard class predicts each transaction from its own route table; plain tasks drive
// directed and random write and lookup transactions. Depends on ilpm_pkg.
`timescale 1ns / 1ps

module ipv4_longest_prefix_match_top_tb;

    import ilpm_pkg::*;

    typedef struct packed {
        logic               mode;
        logic [ENTRY_W-1:0] entry_index;
        logic               entry_enable;
        logic [ADDR_W-1:0]  route_network;
        logic [PFX_W-1:0]   route_prefix;
        logic [PEER_W-1:0]  route_peer;
        logic [ADDR_W-1:0]  lookup_address;
    } t_route_op;

    typedef struct packed {
        logic               hit;
        logic [PEER_W-1:0]  peer;
        logic [PFX_W-1:0]   prefix;
        logic [ENTRY_W-1:0] slot;
    } t_route_result;

    class route_scoreboard;
        logic              valid_tbl [TABLE_ENTRIES];
        logic [ADDR_W-1:0] net_tbl   [TABLE_ENTRIES];
        logic [PFX_W-1:0]  pfx_tbl   [TABLE_ENTRIES];
        logic [PEER_W-1:0] peer_tbl  [TABLE_ENTRIES];
        t_route_result     expected_q [$];
        int                mismatches;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_tbl[i] = 1'b0;
                net_tbl[i]   = '0;
                pfx_tbl[i]   = '0;
                peer_tbl[i]  = '0;
            end
            mismatches = 0;
        endfunction

        function logic [ADDR_W-1:0] route_mask(logic [PFX_W-1:0] pfx_len);
            logic [63:0] host_span;
            host_span = (64'd1 << (32 - int'(pfx_len))) - 64'd1;
            return ~host_span[ADDR_W-1:0];
        endfunction

        function void note_transaction(t_route_op op);
            t_route_result res;
            logic          ok;
            res = '0;
            if (op.mode == MODE_WRITE) begin
                if (int'(op.entry_index) < TABLE_ENTRIES) begin
                    ok = op.entry_enable && (op.route_prefix <= MAX_PREFIX)
                        && (int'(op.route_peer) < PEER_COUNT);
                    valid_tbl[op.entry_index] = ok;
                    if (ok) begin
                        net_tbl[op.entry_index]  = op.route_network;
                        pfx_tbl[op.entry_index]  = op.route_prefix;
                        peer_tbl[op.entry_index] = op.route_peer;
                    end
                end
            end else begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (valid_tbl[i]
                        && ((op.lookup_address ^ net_tbl[i]) & route_mask(pfx_tbl[i])) == '0
                        && (!res.hit || pfx_tbl[i] > res.prefix)) begin
                        res.hit    = 1'b1;
                        res.peer   = peer_tbl[i];
                        res.prefix = pfx_tbl[i];
                        res.slot   = ENTRY_W'(i);
                    end
                end
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 100) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) begin
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
            end
        endtask

        task check_result(logic hit, logic [PEER_W-1:0] peer, logic [PFX_W-1:0] prefix,
                          logic [ENTRY_W-1:0] slot);
            t_route_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = expected_q.pop_front();
                compare_field("hit", int'(hit), int'(want.hit));
                compare_field("matched_peer", int'(peer), int'(want.peer));
                compare_field("matched_prefix", int'(prefix), int'(want.prefix));
                compare_field("matched_slot", int'(slot), int'(want.slot));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic [ENTRY_W-1:0] i_entry_index;
    logic               i_entry_enable;
    logic [ADDR_W-1:0]  i_route_network;
    logic [PFX_W-1:0]   i_route_prefix;
    logic [PEER_W-1:0]  i_route_peer;
    logic [ADDR_W-1:0]  i_lookup_address;
    logic               o_done;
    logic               o_hit;
    logic [PEER_W-1:0]  o_matched_peer;
    logic [PFX_W-1:0]   o_matched_prefix;
    logic [ENTRY_W-1:0] o_matched_slot;

    route_scoreboard    sb = new();
    logic [ADDR_W-1:0]  net_pool [4];
    int                 idle_pct [4] = '{0, 52, 0, 8};

    ipv4_longest_prefix_match_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_entry_index    (i_entry_index),
        .i_entry_enable   (i_entry_enable),
        .i_route_network  (i_route_network),
        .i_route_prefix   (i_route_prefix),
        .i_route_peer     (i_route_peer),
        .i_lookup_address (i_lookup_address),
        .o_done           (o_done),
        .o_hit            (o_hit),
        .o_matched_peer   (o_matched_peer),
        .o_matched_prefix (o_matched_prefix),
        .o_matched_slot   (o_matched_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_hit, o_matched_peer, o_matched_prefix, o_matched_slot);
        end
    end

    function automatic t_route_op noise_op();
        t_route_op op;
        op.mode           = 1'($urandom);
        op.entry_index    = ENTRY_W'($urandom);
        op.entry_enable   = 1'($urandom);
        op.route_network  = $urandom;
        op.route_prefix   = PFX_W'($urandom);
        op.route_peer     = PEER_W'($urandom);
        op.lookup_address = $urandom;
        return op;
    endfunction

    function automatic t_route_op write_op(int idx, logic en, logic [ADDR_W-1:0] net,
                                           int pfx, int peer);
        t_route_op op;
        op                = noise_op();
        op.mode           = MODE_WRITE;
        op.entry_index    = ENTRY_W'(idx);
        op.entry_enable   = en;
        op.route_network  = net;
        op.route_prefix   = PFX_W'(pfx);
        op.route_peer     = PEER_W'(peer);
        return op;
    endfunction

    function automatic t_route_op lookup_op(logic [ADDR_W-1:0] addr);
        t_route_op op;
        op                = noise_op();
        op.mode           = MODE_LOOKUP;
        op.lookup_address = addr;
        return op;
    endfunction

    function automatic t_route_op random_op();
        t_route_op         op;
        int                sel;
        int                s;
        logic [ADDR_W-1:0] base;
        op   = noise_op();
        sel  = $urandom_range(99);
        base = net_pool[$urandom_range(3)]
            ^ ($urandom & ~sb.route_mask(PFX_W'($urandom_range(32, 4))));
        if ($urandom_range(99) < 35) begin
            op.mode         = MODE_WRITE;
            op.entry_enable = ($urandom_range(9) != 0);
            if (sel < 8) begin
                op.route_prefix = PFX_W'($urandom_range(63, 33));
            end else if (sel < 16) begin
                op.route_prefix = ($urandom_range(1) != 0) ? PFX_W'(0) : MAX_PREFIX;
            end else begin
                op.route_prefix = PFX_W'($urandom_range(32, 4));
            end
            if (sel % 10 != 0) begin
                op.route_network = base;
            end
        end else begin
            op.mode = MODE_LOOKUP;
            s       = $urandom_range(TABLE_ENTRIES - 1);
            if (sel < 70 && sb.valid_tbl[s]) begin
                op.lookup_address = sb.net_tbl[s] ^ ($urandom & ~sb.route_mask(sb.pfx_tbl[s]));
            end else if (sel < 92) begin
                op.lookup_address = base;
            end
        end
        return op;
    endfunction

    task automatic drive_op(t_route_op op, int gap_pct);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start            <= 1'b1;
        i_mode           <= op.mode;
        i_entry_index    <= op.entry_index;
        i_entry_enable   <= op.entry_enable;
        i_route_network  <= op.route_network;
        i_route_prefix   <= op.route_prefix;
        i_route_peer     <= op.route_peer;
        i_lookup_address <= op.lookup_address;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_transaction(op);
        @(negedge i_clk);
    endtask

    initial begin
        start            = 1'b0;
        i_rst_n          = 1'b0;
        i_mode           = MODE_LOOKUP;
        i_entry_index    = '0;
        i_entry_enable   = 1'b0;
        i_route_network  = '0;
        i_route_prefix   = '0;
        i_route_peer     = '0;
        i_lookup_address = '0;
        for (int k = 0; k < 4; k++) begin
            net_pool[k] = $urandom;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, default route with host bits, ties, host route, invalidation
        drive_op(lookup_op(32'h0000_0000), 0);
        drive_op(write_op(0, 1'b1, 32'hffff_ffff, 0, 5), 0);
        drive_op(lookup_op(32'hffff_ffff), 0);
        drive_op(lookup_op(32'h0000_0000), 0);
        drive_op(write_op(63, 1'b1, 32'hc0a8_01ff, 24, 15), 0);
        drive_op(lookup_op(32'hc0a8_0100), 0);
        drive_op(write_op(10, 1'b1, 32'hc0a8_0100, 24, 3), 0);
        drive_op(lookup_op(32'hc0a8_0155), 0);
        drive_op(write_op(20, 1'b1, 32'hc0a8_0101, 32, 7), 0);
        drive_op(lookup_op(32'hc0a8_0101), 0);
        drive_op(lookup_op(32'hc0a8_0102), 0);
        drive_op(write_op(20, 1'b1, 32'hc0a8_0101, 33, 7), 0);
        drive_op(lookup_op(32'hc0a8_0101), 0);
        drive_op(write_op(10, 1'b0, 32'hc0a8_0100, 24, 3), 0);
        drive_op(lookup_op(32'hc0a8_0101), 0);
        drive_op(write_op(5, 1'b1, 32'h0000_0000, 63, 0), 0);
        drive_op(write_op(1, 1'b1, 32'h8000_0000, 1, 0), 0);
        drive_op(lookup_op(32'h8000_0000), 0);
        drive_op(lookup_op(32'h7fff_ffff), 0);
        drive_op(write_op(0, 1'b0, 32'h0000_0000, 0, 0), 0);
        drive_op(write_op(2, 1'b1, 32'hffff_fffe, 31, 9), 0);
        drive_op(lookup_op(32'hffff_ffff), 0);
        drive_op(lookup_op(32'h1234_5678), 0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 200; n++) begin
                drive_op(random_op(), idle_pct[ph]);
            end
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
